// ===== rtl/mand_pkg.sv =====
// ============================================================================
// mand_pkg
// Shared types, constants and fixed-point helpers for the Mandelbrot
// escape-time pixel core.
// ============================================================================
`default_nettype none

package mand_pkg;

    // Fixed-point format and sizes
    localparam int FRAC_BITS  = 24;
    localparam int DIM_BITS   = 12;
    localparam int FX_W       = 32;
    localparam int CNT_W      = 16;
    localparam int LIM_W      = 31;
    localparam int DIMR_W     = DIM_BITS + 1;
    localparam int MAP_W      = FX_W + DIM_BITS + 1;   // signed span * pixel
    localparam int DIV_W      = MAP_W - 1;             // dividend magnitude
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int GRAY_W     = 8;

    // Configuration port
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic signed [FX_W-1:0] t_fx;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RE_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RE_SPAN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IM_START = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IM_SPAN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    // Reset values: -2.0, 4.0, -2.0, 4.0, 5.0, 150, 320, 240
    localparam t_fx                RST_START  = -(t_fx'(2) <<< FRAC_BITS);
    localparam t_fx                RST_SPAN   = t_fx'(4) <<< FRAC_BITS;
    localparam logic [LIM_W-1:0]   RST_ESCAPE = LIM_W'(5) << FRAC_BITS;
    localparam logic [CNT_W-1:0]   RST_MAXIT  = CNT_W'(150);
    localparam logic [DIMR_W-1:0]  RST_WIDTH  = DIMR_W'(320);
    localparam logic [DIMR_W-1:0]  RST_HEIGHT = DIMR_W'(240);

    localparam t_fx FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam t_fx FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    // Configuration register file contents
    typedef struct packed {
        t_fx                re_start;
        t_fx                re_span;
        t_fx                im_start;
        t_fx                im_span;
        logic [LIM_W-1:0]   escape_limit;
        logic [CNT_W-1:0]   max_iterations;
        logic [DIMR_W-1:0]  image_width;
        logic [DIMR_W-1:0]  image_height;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load_pix;
        logic map_mul;
        logic sel_im;
        logic div_load_map;
        logic div_load_gray;
        logic div_step;
        logic map_write;
        logic iter_init;
        logic iter_prod;
        logic iter_update;
        logic out_write;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic iter_go;
    } t_dp_sts;

    // Sign extension of a fixed-point value to 64 bits
    function automatic logic signed [63:0] sx64(input t_fx v);
        return {{(64-FX_W){v[FX_W-1]}}, v};
    endfunction

    // Saturate a 64-bit signed value to the fixed-point range
    function automatic t_fx sat_fx(input logic signed [63:0] v);
        if (v > sx64(FX_MAX)) begin
            return FX_MAX;
        end else if (v < sx64(FX_MIN)) begin
            return FX_MIN;
        end else begin
            return v[FX_W-1:0];
        end
    endfunction

    // Fixed-point product: floor shift by FRAC_BITS, then saturate
    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = sx64(a) * sx64(b);
        s = p >>> FRAC_BITS;
        return sat_fx(s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mand_pix_if.sv =====
// ============================================================================
// mand_pix_if
// Pixel coordinate channel: valid/ready handshake with pixel_x and pixel_y.
// ============================================================================
`default_nettype none

interface mand_pix_if
    import mand_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] pixel_x;
    logic [DIM_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/mand_res_if.sv =====
// ============================================================================
// mand_res_if
// Result channel: valid/ready handshake with iteration count and gray level.
// ============================================================================
`default_nettype none

interface mand_res_if
    import mand_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  iteration_count;
    logic [GRAY_W-1:0] gray_level;

    modport source (output valid, output iteration_count, output gray_level,
                    input ready);
    modport sink   (input valid, input iteration_count, input gray_level,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_core.sv =====
// Each pixel is mapped with one 44-step divide per axis, then iterated, then
// its gray level is found with one more divide. Each iteration forms three
// parallel products, then tests and updates. One pixel in flight; the next
// transfer is taken while the result waits. Reset (i_rst_n, synchronous,
// active low) restores the default window and limits, and empties the pipeline.
// ============================================================================
// mandelbrot_escape_time_pixel_core
// Mandelbrot escape-time evaluator for one pixel, Q8.24 fixed point.
// ============================================================================
`default_nettype none

module mandelbrot_escape_time_pixel_core
    import mand_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    mand_pix_if.sink               i_pix,
    mand_res_if.source             o_res
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers
    mand_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    mand_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic
    mand_dp u_dp (
        .i_clk             (i_clk),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_pixel_x         (i_pix.pixel_x),
        .i_pixel_y         (i_pix.pixel_y),
        .o_iteration_count (o_res.iteration_count),
        .o_gray_level      (o_res.gray_level)
    );

endmodule

`default_nettype wire

// ===== rtl/mand_regs.sv =====
// ============================================================================
// mand_regs
// APB-style configuration register file for the window, limits and image size.
// ============================================================================
`default_nettype none

module mand_regs
    import mand_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.re_start       <= RST_START;
            r_cfg.re_span        <= RST_SPAN;
            r_cfg.im_start       <= RST_START;
            r_cfg.im_span        <= RST_SPAN;
            r_cfg.escape_limit   <= RST_ESCAPE;
            r_cfg.max_iterations <= RST_MAXIT;
            r_cfg.image_width    <= RST_WIDTH;
            r_cfg.image_height   <= RST_HEIGHT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RE_START: r_cfg.re_start       <= pwdata;
                REG_RE_SPAN:  r_cfg.re_span        <= pwdata;
                REG_IM_START: r_cfg.im_start       <= pwdata;
                REG_IM_SPAN:  r_cfg.im_span        <= pwdata;
                REG_ESCAPE:   r_cfg.escape_limit   <= pwdata[LIM_W-1:0];
                REG_MAX_ITER: r_cfg.max_iterations <= pwdata[CNT_W-1:0];
                REG_WIDTH:    r_cfg.image_width    <= pwdata[DIMR_W-1:0];
                REG_HEIGHT:   r_cfg.image_height   <= pwdata[DIMR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_RE_START: prdata = r_cfg.re_start;
            REG_RE_SPAN:  prdata = r_cfg.re_span;
            REG_IM_START: prdata = r_cfg.im_start;
            REG_IM_SPAN:  prdata = r_cfg.im_span;
            REG_ESCAPE:   prdata = APB_DW'(r_cfg.escape_limit);
            REG_MAX_ITER: prdata = APB_DW'(r_cfg.max_iterations);
            REG_WIDTH:    prdata = APB_DW'(r_cfg.image_width);
            REG_HEIGHT:   prdata = APB_DW'(r_cfg.image_height);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mand_ctrl.sv =====
// ============================================================================
// mand_ctrl
// Sequencer for one pixel: mapping, iteration loop, gray division and the
// output handshake.
// ============================================================================
`default_nettype none

module mand_ctrl
    import mand_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_DLD  = 11'b000_0000_0100,
        S_DIV  = 11'b000_0000_1000,
        S_MAPW = 11'b000_0001_0000,
        S_INIT = 11'b000_0010_0000,
        S_PROD = 11'b000_0100_0000,
        S_TEST = 11'b000_1000_0000,
        S_GLD  = 11'b001_0000_0000,
        S_GDIV = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    t_state               r_state, n_state;
    logic                 r_sel_im, n_sel_im;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_vld, n_out_vld;
    logic                 out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign out_free    = !r_out_vld || i_out_ready;

    // Next-state and command decode
    always_comb begin
        n_state   = r_state;
        n_sel_im  = r_sel_im;
        n_div_cnt = r_div_cnt;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        o_cmd.sel_im = r_sel_im;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_pix = 1'b1;
                    n_sel_im       = 1'b0;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_DLD;
            end
            S_DLD: begin
                o_cmd.div_load_map = 1'b1;
                n_div_cnt          = '0;
                n_state            = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_MAPW;
                end
            end
            S_MAPW: begin
                o_cmd.map_write = 1'b1;
                if (r_sel_im) begin
                    n_state = S_INIT;
                end else begin
                    n_sel_im = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_INIT: begin
                o_cmd.iter_init = 1'b1;
                n_state         = S_PROD;
            end
            S_PROD: begin
                o_cmd.iter_prod = 1'b1;
                n_state         = S_TEST;
            end
            S_TEST: begin
                if (i_sts.iter_go) begin
                    o_cmd.iter_update = 1'b1;
                    n_state           = S_PROD;
                end else begin
                    n_state = S_GLD;
                end
            end
            S_GLD: begin
                o_cmd.div_load_gray = 1'b1;
                n_div_cnt           = '0;
                n_state             = S_GDIV;
            end
            S_GDIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait until the output register is free
                if (out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_out_vld       = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel_im  <= 1'b0;
            r_div_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel_im  <= n_sel_im;
            r_div_cnt <= n_div_cnt;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mand_dp.sv =====
// ============================================================================
// mand_dp
// Datapath: coordinate mapping multiplier, shared restoring divider,
// iteration multipliers and update adders, output register.
// ============================================================================
`default_nettype none

module mand_dp
    import mand_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_cfg                i_cfg,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [DIM_BITS-1:0] i_pixel_x,
    input  wire logic [DIM_BITS-1:0] i_pixel_y,
    output logic      [CNT_W-1:0]    o_iteration_count,
    output logic      [GRAY_W-1:0]   o_gray_level
);

    // Payload registers
    logic [DIM_BITS-1:0]     r_px, r_py;
    logic signed [MAP_W-1:0] r_map_prod;
    logic [DIV_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_dvs;
    logic                    r_div_neg;
    t_fx                     r_cre, r_cim;
    t_fx                     r_x, r_y;
    t_fx                     r_xx, r_yy, r_xy;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_out_cnt;
    logic [GRAY_W-1:0]       r_out_gray;

    // Combinational helpers
    logic [MAP_W-1:0]        map_mag;
    logic [DIMR_W-1:0]       dim_sel;
    logic [CNT_W:0]          rem_sh;
    logic                    rem_ge;
    logic [MAP_W-1:0]        map_q;
    logic signed [63:0]      map_sum;
    logic signed [FX_W+1:0]  mag_sq;
    logic signed [FX_W+1:0]  lim_ext;
    logic [23:0]             gray_num;

    // Mapping: magnitude of the product and divisor choice
    always_comb begin
        map_mag = r_map_prod[MAP_W-1] ? (MAP_W'(0) - MAP_W'(r_map_prod))
                                      : MAP_W'(r_map_prod);
        dim_sel = i_cmd.sel_im ? i_cfg.image_height : i_cfg.image_width;
    end

    // Divider step: shift in one dividend bit, compare and subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_dvs});
    end

    // Signed quotient plus window start
    always_comb begin
        map_q   = r_div_neg ? (MAP_W'(0) - {1'b0, r_quo}) : {1'b0, r_quo};
        map_sum = sx64(i_cmd.sel_im ? i_cfg.im_start : i_cfg.re_start)
                + {{(64-MAP_W){map_q[MAP_W-1]}}, map_q};
    end

    // Escape and budget test on the exact sum of the clamped squares; gray numerator
    always_comb begin
        mag_sq        = {{2{r_xx[FX_W-1]}}, r_xx} + {{2{r_yy[FX_W-1]}}, r_yy};
        lim_ext       = {3'b000, i_cfg.escape_limit};
        o_sts.iter_go = (mag_sq <= lim_ext) && (r_count < i_cfg.max_iterations);
        gray_num      = {r_count, 8'h00} - {8'h00, r_count};   // count * 255
    end

    // Pixel latch and mapping product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.map_mul) begin
            r_map_prod <= i_cmd.sel_im ? (i_cfg.im_span * $signed({1'b0, r_py}))
                                       : (i_cfg.re_span * $signed({1'b0, r_px}));
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load_map) begin
            r_quo     <= map_mag[DIV_W-1:0];
            r_rem     <= '0;
            r_div_neg <= r_map_prod[MAP_W-1];
            r_dvs     <= (dim_sel == '0) ? CNT_W'(1) : CNT_W'(dim_sel);
        end else if (i_cmd.div_load_gray) begin
            r_quo     <= DIV_W'(gray_num);
            r_rem     <= '0;
            r_div_neg <= 1'b0;
            r_dvs     <= (i_cfg.max_iterations == '0) ? CNT_W'(1)
                                                      : i_cfg.max_iterations;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CNT_W-1:0];
        end
    end

    // Mapped point c
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_write) begin
            if (i_cmd.sel_im) begin
                r_cim <= sat_fx(map_sum);
            end else begin
                r_cre <= sat_fx(map_sum);
            end
        end
    end

    // Iteration: products, then update of z and the count
    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_init) begin
            r_x     <= r_cre;
            r_y     <= r_cim;
            r_count <= '0;
        end else if (i_cmd.iter_update) begin
            r_x     <= sat_fx(sx64(r_xx) - sx64(r_yy) + sx64(r_cre));
            r_y     <= sat_fx(sx64(r_xy) + sx64(r_xy) + sx64(r_cim));
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.iter_prod) begin
            r_xx <= fx_mul(r_x, r_x);
            r_yy <= fx_mul(r_y, r_y);
            r_xy <= fx_mul(r_x, r_y);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out_cnt  <= r_count;
            r_out_gray <= r_quo[GRAY_W-1:0];
        end
    end

    assign o_iteration_count = r_out_cnt;
    assign o_gray_level      = r_out_gray;

endmodule

`default_nettype wire

// ===== tb/mand_escape_checker.sv =====
// ============================================================================
// mand_escape_checker
// Watches the register port and both streams of the escape-time core. It
// keeps its own copy of the window registers and works out the iteration
// count and gray level of every accepted pixel. Each returned result is
// compared in order against the oldest outstanding prediction.
// ============================================================================
module mand_escape_checker
    import mand_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    mand_pix_if               i_pix,
    mand_res_if               i_res,
    output int                o_pending,
    output int                o_result_count,
    output int                o_fail_count
);

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [GRAY_W-1:0] gray;
    } t_escape;

    // Local copy of the register file
    t_fx               re_start     = RST_START;
    t_fx               re_span      = RST_SPAN;
    t_fx               im_start     = RST_START;
    t_fx               im_span      = RST_SPAN;
    logic [LIM_W-1:0]  escape_limit = RST_ESCAPE;
    logic [CNT_W-1:0]  iter_budget  = RST_MAXIT;
    logic [DIMR_W-1:0] img_w        = RST_WIDTH;
    logic [DIMR_W-1:0] img_h        = RST_HEIGHT;

    t_escape escape_q[$];
    int      results = 0;
    int      fails   = 0;

    initial begin
        o_pending      = 0;
        o_result_count = 0;
        o_fail_count   = 0;
    end

    // Clamp to the Q8.24 range
    function automatic t_fx clip_fx(input longint v);
        if (v > longint'(FX_MAX)) return FX_MAX;
        if (v < longint'(FX_MIN)) return FX_MIN;
        return v[FX_W-1:0];
    endfunction

    // Fixed-point product, floor shift, clamped
    function automatic t_fx q_mul(input t_fx a, input t_fx b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip_fx(p >>> FRAC_BITS);
    endfunction

    // Pixel index to plane coordinate; a zero dimension divides as one
    function automatic t_fx map_axis(input t_fx origin, input t_fx extent,
                                     input logic [DIM_BITS-1:0] pix,
                                     input logic [DIMR_W-1:0] dim);
        longint divisor;
        divisor = (dim == '0) ? 64'sd1 : longint'(dim);
        return clip_fx(longint'(origin) + (longint'(extent) * longint'(pix)) / divisor);
    endfunction

    // Escape-time iteration for one pixel
    function automatic t_escape escape_time(input logic [DIM_BITS-1:0] px,
                                            input logic [DIM_BITS-1:0] py);
        t_fx         c_re, c_im, zr, zi, rr, ii, ri;
        int unsigned left;
        int unsigned done;
        t_escape     r;
        c_re = map_axis(re_start, re_span, px, img_w);
        c_im = map_axis(im_start, im_span, py, img_h);
        zr   = c_re;
        zi   = c_im;
        rr   = q_mul(zr, zr);
        ii   = q_mul(zi, zi);
        ri   = q_mul(zr, zi);
        left = iter_budget;
        // the sum of squares is exact; the products and the updates clamp
        while ((longint'(rr) + longint'(ii) <= longint'(escape_limit)) && left > 0) begin
            left--;
            zr = clip_fx(longint'(rr) - longint'(ii) + longint'(c_re));
            zi = clip_fx(2 * longint'(ri) + longint'(c_im));
            rr = q_mul(zr, zr);
            ii = q_mul(zi, zi);
            ri = q_mul(zr, zi);
        end
        done    = iter_budget - left;
        r.count = done[CNT_W-1:0];
        r.gray  = (iter_budget == '0) ? '0 : GRAY_W'((done * 255) / iter_budget);
        return r;
    endfunction

    // Register writes, result compare, then new predictions
    always @(posedge i_clk) begin : watch
        t_escape want;
        if (!i_rst_n) begin
            re_start     = RST_START;
            re_span      = RST_SPAN;
            im_start     = RST_START;
            im_span      = RST_SPAN;
            escape_limit = RST_ESCAPE;
            iter_budget  = RST_MAXIT;
            img_w        = RST_WIDTH;
            img_h        = RST_HEIGHT;
            escape_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2 +: REG_IDX_W])
                    REG_RE_START: re_start     = pwdata;
                    REG_RE_SPAN:  re_span      = pwdata;
                    REG_IM_START: im_start     = pwdata;
                    REG_IM_SPAN:  im_span      = pwdata;
                    REG_ESCAPE:   escape_limit = pwdata[LIM_W-1:0];
                    REG_MAX_ITER: iter_budget  = pwdata[CNT_W-1:0];
                    REG_WIDTH:    img_w        = pwdata[DIMR_W-1:0];
                    REG_HEIGHT:   img_h        = pwdata[DIMR_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                results++;
                if (escape_q.size() == 0) begin
                    $error("unexpected result: iteration_count %0d, gray_level %0d",
                           i_res.iteration_count, i_res.gray_level);
                    fails++;
                end else begin
                    want = escape_q.pop_front();
                    if (i_res.iteration_count !== want.count) begin
                        $error("iteration_count mismatch: expected %0d, got %0d",
                               want.count, i_res.iteration_count);
                        fails++;
                    end
                    if (i_res.gray_level !== want.gray) begin
                        $error("gray_level mismatch: expected %0d, got %0d",
                               want.gray, i_res.gray_level);
                        fails++;
                    end
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                escape_q.push_back(escape_time(i_pix.pixel_x, i_pix.pixel_y));
            end
        end
        o_pending      <= escape_q.size();
        o_result_count <= results;
        o_fail_count   <= fails;
    end

endmodule

// ===== tb/mandelbrot_escape_time_pixel_core_tb.sv =====
// ============================================================================
// mandelbrot_escape_time_pixel_core_tb
// Drives pixel coordinates and window settings into the escape-time core
// and returns the verdict. A directed pass covers the reset window, a zero
// budget, zero dimensions, clamped mapping and iteration, a zero escape
// limit and the full budget; random windows follow, with random idle gaps
// on the pixel stream and random stalls on the result stream.
// ============================================================================
module mandelbrot_escape_time_pixel_core_tb;
    import mand_pkg::*;

    localparam int     CLK_HALF       = 10;
    localparam int     RANDOM_SETS    = 12;
    localparam int     PIXELS_PER_SET = 150;
    localparam longint CYCLE_LIMIT    = 6_000_000;
    localparam int     FX_ONE         = 1 << FRAC_BITS;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int     pending;
    int     result_count;
    int     fail_count;
    int     pixels_sent  = 0;
    int     window_count = 0;
    longint cycles       = 0;
    bit     gaps_on      = 1'b1;
    bit     stalls_on    = 1'b1;

    mand_pix_if pix_if();
    mand_res_if res_if();

    mandelbrot_escape_time_pixel_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    mand_escape_checker escape_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .i_pix          (pix_if),
        .i_res          (res_if),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_fail_count   (fail_count)
    );

    // Clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stall before each transfer
    initial begin : result_sink
        int hold;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = stalls_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // Register write: setup phase, access phase until pready, then the bus goes idle
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_window(input t_fx re_s, input t_fx re_w,
                               input t_fx im_s, input t_fx im_w,
                               input logic [APB_DW-1:0] esc,
                               input logic [APB_DW-1:0] iters,
                               input logic [APB_DW-1:0] cols,
                               input logic [APB_DW-1:0] rows);
        reg_write(REG_RE_START, re_s);
        reg_write(REG_RE_SPAN, re_w);
        reg_write(REG_IM_START, im_s);
        reg_write(REG_IM_SPAN, im_w);
        reg_write(REG_ESCAPE, esc);
        reg_write(REG_MAX_ITER, iters);
        reg_write(REG_WIDTH, cols);
        reg_write(REG_HEIGHT, rows);
        window_count++;
    endtask

    // Drop valid and hold until every predicted result is back
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One pixel transfer; valid stays high for a back-to-back follower
    task automatic send_pixel(input logic [DIM_BITS-1:0] x, input logic [DIM_BITS-1:0] y);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.pixel_x <= x;
        pix_if.pixel_y <= y;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Window origin: mostly around the set, sometimes anywhere
    function automatic t_fx pick_start();
        if ($urandom_range(0, 4) == 0) return t_fx'($urandom);
        return t_fx'($urandom_range(0, 7 * FX_ONE / 2)) - t_fx'(5 * FX_ONE / 2);
    endfunction

    function automatic t_fx pick_span();
        case ($urandom_range(0, 9))
            0:       return t_fx'($urandom);
            1:       return -t_fx'($urandom_range(1 << 16, 4 * FX_ONE));
            default: return t_fx'($urandom_range(1 << 16, 4 * FX_ONE));
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:          return '0;
            1:          return $urandom_range(4097, 8191);
            2, 3, 4, 5: return $urandom_range(1, 4096);
            default:    return $urandom_range(1, 512);
        endcase
    endfunction

    // Mostly inside the image, sometimes any 12-bit index
    function automatic logic [DIM_BITS-1:0] pick_pixel(input logic [APB_DW-1:0] dim);
        if (dim != 0 && dim <= 4096 && $urandom_range(0, 6) != 0) begin
            return DIM_BITS'($urandom_range(0, dim - 1));
        end
        return DIM_BITS'($urandom);
    endfunction

    task automatic random_window(output logic [APB_DW-1:0] cols,
                                 output logic [APB_DW-1:0] rows);
        logic [APB_DW-1:0] esc;
        logic [APB_DW-1:0] iters;
        case ($urandom_range(0, 9))
            0:       esc = '0;
            1:       esc = 32'h7FFF_FFFF;
            2, 3:    esc = $urandom;
            default: esc = 4 * FX_ONE;
        endcase
        case ($urandom_range(0, 19))
            0:       iters = '0;
            1, 2, 3: iters = $urandom_range(65, 255);
            default: iters = $urandom_range(1, 64);
        endcase
        cols = pick_dim();
        rows = pick_dim();
        load_window(pick_start(), pick_span(), pick_start(), pick_span(),
                    esc, iters, cols, rows);
    endtask

    initial begin : stimulus
        logic [APB_DW-1:0] cols;
        logic [APB_DW-1:0] rows;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.pixel_x <= '0;
        pix_if.pixel_y <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window: interior at origin, period-two point, escapes, far corner
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd80, 12'd120);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd319, 12'd239);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        wait_drained();

        // Zero budget
        load_window(RST_START, RST_SPAN, RST_START, RST_SPAN, 5 * FX_ONE, 0, 320, 240);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd0, 12'd0);
        wait_drained();

        // Zero dimensions divide as one
        load_window(-FX_ONE / 2, 1 << 12, -FX_ONE / 2, 1 << 12, 4 * FX_ONE, 40, 0, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1);
        wait_drained();

        // Mapping clamps at both ends; escape register written with bit 31 set
        load_window(FX_MAX, FX_MAX, FX_MIN, FX_MIN, 32'hFFFF_FFFF, 3, 1, 1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd4095);
        wait_drained();

        // Real update clamps inside the escape bound
        load_window(11 * FX_ONE, 0, 0, 0, 32'h7FFF_FFFF, 3, 1, 1);
        send_pixel(12'd0, 12'd0);
        wait_drained();

        // Zero escape limit with a single iteration allowed
        load_window(RST_START, RST_SPAN, RST_START, RST_SPAN, 0, 1, 320, 240);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd0, 12'd0);
        wait_drained();

        // Full budget on an interior point
        load_window(RST_START, RST_SPAN, RST_START, RST_SPAN, 4 * FX_ONE, 16'hFFFF, 320, 240);
        send_pixel(12'd160, 12'd120);
        send_pixel(12'd0, 12'd0);
        wait_drained();

        // Random windows, idle patterns change per set
        for (int s = 0; s < RANDOM_SETS; s++) begin
            random_window(cols, rows);
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PIXELS_PER_SET; k++) begin
                if ($urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
                send_pixel(pick_pixel(cols), pick_pixel(rows));
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (2 * 255 + 150) @(posedge i_clk);
        $display("Checked %0d results for %0d pixels across %0d window settings",
                 result_count, pixels_sent, window_count + 1);
        $display("Corner windows first, then random windows with source gaps and sink stalls");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mand_pkg.sv
rtl/mand_pix_if.sv
rtl/mand_res_if.sv
rtl/mand_regs.sv
rtl/mand_ctrl.sv
rtl/mand_dp.sv
rtl/mandelbrot_escape_time_pixel_core.sv
tb/mand_escape_checker.sv
tb/mandelbrot_escape_time_pixel_core_tb.sv
